### rtl/core/ansi_csi_text_terminal_macros.svh
// Assertion macros shared by the terminal checkers.
// Clock aclk and active-low reset aresetn are taken from the enclosing scope.
`ifndef ANSI_CSI_TEXT_TERMINAL_MACROS_SVH
`define ANSI_CSI_TEXT_TERMINAL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ACSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ACSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/acsi_pkg.sv
// Shared types and constants for the ANSI CSI text terminal.
// No dependencies; used by every module of the block.
package acsi_pkg;

    // Screen geometry
    localparam int ROWS      = 25;
    localparam int COLUMNS   = 80;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int POS_W     = 11;
    localparam int SCROLL_W  = 5;
    localparam int PARAM_W   = 15;
    localparam int PARAM_MAX = 32767;
    localparam int PHASE_W   = 3;

    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h07;

    // Display command codes
    localparam logic [1:0] OP_WRITE       = 2'd0;
    localparam logic [1:0] OP_FILL        = 2'd1;
    localparam logic [1:0] OP_SCROLL_UP   = 2'd2;
    localparam logic [1:0] OP_SCROLL_DOWN = 2'd3;

    // Character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_TILDE    = 8'h7e;

    typedef struct packed {
        logic [1:0]          op;
        logic [POS_W-1:0]    start_pos;
        logic [POS_W-1:0]    end_pos;
        logic [15:0]         cell_word;
        logic [SCROLL_W-1:0] scroll_rows;
        logic                last;
    } result_t;

    // Up to two results produced by one byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

### rtl/core/ansi_csi_text_terminal.sv
// ANSI CSI text terminal: takes one character byte per item and issues display
// commands (cell writes, range fills, scrolls) for an 80 x 25 text screen.
// A byte is held in an input register and decoded in the following cycle,
// when the two-entry result buffer has room; the first result of a byte passes
// through the input register and then the result buffer before it is on the
// m_ ports. Bytes are taken one per cycle as long as each gives at most one
// result and m_ready is high; a byte that gives two results (a write at the
// last cell followed by a scroll) occupies the single result port for both, and
// the next byte waits until the buffer has room again. The default attribute
// register is to be written through cfg_wr_en / cfg_wr_data only while idle;
// the block itself does not enforce this. There is no clearing pass after reset.
module ansi_csi_text_terminal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_op,
    output logic [10:0] m_start_pos,
    output logic [10:0] m_end_pos,
    output logic [15:0] m_cell_word,
    output logic [4:0]  m_scroll_rows,
    output logic        m_last
);
    import acsi_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       room, fire;
    push_t      push_data;
    result_t    head;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_char_byte;
        end
    end

    acsi_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .char_byte   (in_byte_reg),
        .push_data   (push_data)
    );

    acsi_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .push_data (push_data),
        .m_ready   (m_ready),
        .room      (room),
        .m_valid   (m_valid),
        .head      (head)
    );

    assign m_op          = head.op;
    assign m_start_pos   = head.start_pos;
    assign m_end_pos     = head.end_pos;
    assign m_cell_word   = head.cell_word;
    assign m_scroll_rows = head.scroll_rows;
    assign m_last        = head.last;

endmodule

### rtl/core/acsi_parser.sv
// Parse state, cursor and attribute registers plus the per-byte decode logic.
// Depends on acsi_pkg.
module acsi_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            fire,
    input  logic [7:0]      char_byte,
    output acsi_pkg::push_t push_data
);
    import acsi_pkg::*;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ESC    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PARAM1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PARAM2 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PARAMX = 3'd4;

    localparam logic [7:0] FIN_CUU = 8'h41;  // A
    localparam logic [7:0] FIN_CUD = 8'h42;  // B
    localparam logic [7:0] FIN_CUF = 8'h43;  // C
    localparam logic [7:0] FIN_CUB = 8'h44;  // D
    localparam logic [7:0] FIN_CNL = 8'h45;  // E
    localparam logic [7:0] FIN_CPL = 8'h46;  // F
    localparam logic [7:0] FIN_CUP = 8'h48;  // H
    localparam logic [7:0] FIN_ED  = 8'h4a;  // J
    localparam logic [7:0] FIN_EL  = 8'h4b;  // K
    localparam logic [7:0] FIN_SU  = 8'h53;  // S
    localparam logic [7:0] FIN_SD  = 8'h54;  // T
    localparam logic [7:0] FIN_SGR = 8'h6d;  // m

    localparam logic [PARAM_W-1:0] MODE_TO_END    = PARAM_W'(0);
    localparam logic [PARAM_W-1:0] MODE_TO_CURSOR = PARAM_W'(1);
    localparam logic [PARAM_W-1:0] MODE_ALL       = PARAM_W'(2);

    localparam logic [PARAM_W-1:0] SGR_RESET  = PARAM_W'(0);
    localparam logic [PARAM_W-1:0] SGR_BRIGHT = PARAM_W'(1);
    localparam logic [PARAM_W-1:0] SGR_DIM    = PARAM_W'(2);
    localparam logic [PARAM_W-1:0] SGR_FG     = PARAM_W'(30);
    localparam logic [PARAM_W-1:0] SGR_BG     = PARAM_W'(40);
    localparam logic [PARAM_W-1:0] SGR_FG_HI  = PARAM_W'(90);
    localparam logic [PARAM_W-1:0] SGR_BG_HI  = PARAM_W'(100);

    localparam int ACC_W = PARAM_W + 4;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PARAM_W-1:0] p1_reg, p1_next;
    logic [PARAM_W-1:0] p2_reg, p2_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [7:0]         attr_reg, attr_next;
    logic [7:0]         def_attr_reg;

    logic [POS_W-1:0]   line_start, line_end, cur_pos;
    logic [PARAM_W-1:0] n_cnt, m_cnt;
    logic               last_row, last_col, at_end;
    logic [COL_W:0]     tab_target;
    logic [1:0]         tab_step;
    logic [ACC_W-1:0]   acc;
    logic [PARAM_W-1:0] acc_sat, acc_src;
    logic [PARAM_W:0]   row_sum, col_sum;
    logic [ROW_W-1:0]   row_up, row_dn, row_abs;
    logic [COL_W-1:0]   col_rt, col_lf, col_abs;
    logic [SCROLL_W-1:0] scroll_cnt;
    logic [15:0]        blank;
    logic [7:0]         attr_sgr;
    push_t              push_c;

    // ANSI colour order to VGA colour order: swap red and blue bits
    function automatic logic [2:0] swap_rb(input logic [2:0] n);
        return {n[0], n[1], n[2]};
    endfunction

    function automatic logic [2:0] low3(input logic [PARAM_W-1:0] p,
                                       input logic [PARAM_W-1:0] base);
        logic [PARAM_W-1:0] d;
        d = p - base;
        return d[2:0];
    endfunction

    function automatic result_t mk_res(input logic [1:0] op,
                                       input logic [POS_W-1:0] s,
                                       input logic [POS_W-1:0] e,
                                       input logic [15:0] w,
                                       input logic [SCROLL_W-1:0] r);
        result_t t;
        t.op          = op;
        t.start_pos   = s;
        t.end_pos     = e;
        t.cell_word   = w;
        t.scroll_rows = r;
        t.last        = 1'b0;
        return t;
    endfunction

    assign line_start = POS_W'(32'(row_reg) * COLUMNS);
    assign line_end   = line_start + POS_W'(COLUMNS - 1);
    assign cur_pos    = line_start + POS_W'(col_reg);
    assign last_row   = (row_reg == ROW_W'(ROWS - 1));
    assign last_col   = (col_reg == COL_W'(COLUMNS - 1));
    assign at_end     = (cur_pos == POS_W'(CELLS - 1));
    assign blank      = {def_attr_reg, CH_SPACE};

    assign n_cnt = (p1_reg == '0) ? PARAM_W'(1) : p1_reg;
    assign m_cnt = (p2_reg == '0) ? PARAM_W'(1) : p2_reg;

    // Next column congruent to 1 mod 4
    assign tab_step   = 2'(3'd5 - {1'b0, col_reg[1:0]});
    assign tab_target = {1'b0, col_reg} + (COL_W + 1)'(tab_step);

    // Decimal accumulate, saturating; digit value is the low nibble
    assign acc_src = (phase_reg == PH_PARAM1) ? p1_reg : p2_reg;
    assign acc     = {acc_src, 3'b000} + {2'b00, acc_src, 1'b0}
                   + ACC_W'(char_byte[3:0]);
    assign acc_sat = (acc > ACC_W'(PARAM_MAX)) ? PARAM_W'(PARAM_MAX) : acc[PARAM_W-1:0];

    // Cursor moves, all clamped to the screen
    assign row_sum = {1'b0, n_cnt} + (PARAM_W + 1)'(row_reg);
    assign col_sum = {1'b0, n_cnt} + (PARAM_W + 1)'(col_reg);
    assign row_up  = (n_cnt > PARAM_W'(row_reg)) ? '0 : row_reg - n_cnt[ROW_W-1:0];
    assign row_dn  = (row_sum > (PARAM_W + 1)'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                          : row_sum[ROW_W-1:0];
    assign col_lf  = (n_cnt > PARAM_W'(col_reg)) ? '0 : col_reg - n_cnt[COL_W-1:0];
    assign col_rt  = (col_sum > (PARAM_W + 1)'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                             : col_sum[COL_W-1:0];
    assign row_abs = (n_cnt > PARAM_W'(ROWS)) ? ROW_W'(ROWS - 1)
                                              : ROW_W'(n_cnt - PARAM_W'(1));
    assign col_abs = (m_cnt > PARAM_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                 : COL_W'(m_cnt - PARAM_W'(1));
    assign scroll_cnt = (n_cnt > PARAM_W'(ROWS)) ? SCROLL_W'(ROWS)
                                                 : n_cnt[SCROLL_W-1:0];

    always_comb begin
        attr_sgr = attr_reg;
        if (p1_reg == SGR_RESET) begin
            attr_sgr = def_attr_reg;
        end else if (p1_reg == SGR_BRIGHT) begin
            attr_sgr = attr_reg | 8'h88;
        end else if (p1_reg == SGR_DIM) begin
            attr_sgr = attr_reg & 8'h77;
        end else if (p1_reg >= SGR_FG && p1_reg <= SGR_FG + PARAM_W'(7)) begin
            attr_sgr = {attr_reg[7:3], swap_rb(low3(p1_reg, SGR_FG))};
        end else if (p1_reg >= SGR_BG && p1_reg <= SGR_BG + PARAM_W'(7)) begin
            attr_sgr = {attr_reg[7], swap_rb(low3(p1_reg, SGR_BG)), attr_reg[3:0]};
        end else if (p1_reg >= SGR_FG_HI && p1_reg <= SGR_FG_HI + PARAM_W'(7)) begin
            attr_sgr = {attr_reg[7:4], 1'b1, swap_rb(low3(p1_reg, SGR_FG_HI))};
        end else if (p1_reg >= SGR_BG_HI && p1_reg <= SGR_BG_HI + PARAM_W'(7)) begin
            attr_sgr = {1'b1, swap_rb(low3(p1_reg, SGR_BG_HI)), attr_reg[3:0]};
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        attr_next   = attr_reg;
        push_c      = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                case (char_byte)
                    CH_BS: begin
                        if (col_reg == '0) begin
                            col_next = COL_W'(COLUMNS - 1);
                            if (row_reg != '0) begin
                                row_next = row_reg - ROW_W'(1);
                            end else begin
                                push_c.res0 = mk_res(OP_SCROLL_DOWN, '0, '0, '0, SCROLL_W'(1));
                                push_c.cnt  = 2'd1;
                            end
                        end else begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                    CH_TAB: begin
                        if (!at_end && col_reg[1:0] != 2'd1) begin
                            if (tab_target < (COL_W + 1)'(COLUMNS)) begin
                                col_next = tab_target[COL_W-1:0];
                            end else begin
                                col_next = COL_W'(1);
                                if (last_row) begin
                                    push_c.res0 = mk_res(OP_SCROLL_UP, '0, '0, '0,
                                                         SCROLL_W'(1));
                                    push_c.cnt  = 2'd1;
                                end else begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                        end
                    end
                    CH_LF: begin
                        col_next = '0;
                        if (last_row) begin
                            push_c.res0 = mk_res(OP_SCROLL_UP, '0, '0, '0, SCROLL_W'(1));
                            push_c.cnt  = 2'd1;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    CH_ESC: begin
                        phase_next = PH_ESC;
                    end
                    default: begin
                        push_c.res0 = mk_res(OP_WRITE, cur_pos, cur_pos,
                                             {attr_reg, char_byte}, '0);
                        push_c.cnt  = 2'd1;
                        if (last_col) begin
                            col_next = '0;
                            if (last_row) begin
                                push_c.res1 = mk_res(OP_SCROLL_UP, '0, '0, '0,
                                                     SCROLL_W'(1));
                                push_c.cnt  = 2'd2;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                endcase
            end
            PH_ESC: begin
                if (char_byte == CH_LBRACKET) begin
                    phase_next = PH_PARAM1;
                    p1_next    = '0;
                    p2_next    = '0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
                    if (phase_reg == PH_PARAM1) begin
                        p1_next = acc_sat;
                    end else if (phase_reg == PH_PARAM2) begin
                        p2_next = acc_sat;
                    end
                end else if (char_byte == CH_SEMI) begin
                    if (phase_reg == PH_PARAM1) begin
                        phase_next = PH_PARAM2;
                    end else begin
                        phase_next = PH_PARAMX;
                    end
                end else if (char_byte >= CH_FINAL_LO && char_byte <= CH_TILDE) begin
                    phase_next = PH_IDLE;
                    case (char_byte)
                        FIN_CUU: row_next = row_up;
                        FIN_CUD: row_next = row_dn;
                        FIN_CUF: col_next = col_rt;
                        FIN_CUB: col_next = col_lf;
                        FIN_CNL: begin
                            row_next = row_dn;
                            col_next = '0;
                        end
                        FIN_CPL: begin
                            row_next = row_up;
                            col_next = '0;
                        end
                        FIN_CUP: begin
                            row_next = row_abs;
                            col_next = col_abs;
                        end
                        FIN_ED: begin
                            if (p1_reg == MODE_TO_END) begin
                                push_c.res0 = mk_res(OP_FILL, cur_pos, POS_W'(CELLS - 1),
                                                     blank, '0);
                                push_c.cnt  = 2'd1;
                            end else if (p1_reg == MODE_TO_CURSOR) begin
                                push_c.res0 = mk_res(OP_FILL, '0, cur_pos, blank, '0);
                                push_c.cnt  = 2'd1;
                            end else if (p1_reg == MODE_ALL) begin
                                push_c.res0 = mk_res(OP_FILL, '0, POS_W'(CELLS - 1),
                                                     blank, '0);
                                push_c.cnt  = 2'd1;
                            end
                        end
                        FIN_EL: begin
                            if (p1_reg == MODE_TO_END) begin
                                push_c.res0 = mk_res(OP_FILL, cur_pos, line_end, blank, '0);
                                push_c.cnt  = 2'd1;
                            end else if (p1_reg == MODE_TO_CURSOR) begin
                                push_c.res0 = mk_res(OP_FILL, line_start, cur_pos, blank, '0);
                                push_c.cnt  = 2'd1;
                            end else if (p1_reg == MODE_ALL) begin
                                push_c.res0 = mk_res(OP_FILL, line_start, line_end,
                                                     blank, '0);
                                push_c.cnt  = 2'd1;
                            end
                        end
                        FIN_SU: begin
                            push_c.res0 = mk_res(OP_SCROLL_UP, '0, '0, '0, scroll_cnt);
                            push_c.cnt  = 2'd1;
                        end
                        FIN_SD: begin
                            push_c.res0 = mk_res(OP_SCROLL_DOWN, '0, '0, '0, scroll_cnt);
                            push_c.cnt  = 2'd1;
                        end
                        FIN_SGR: attr_next = attr_sgr;
                        default: ;
                    endcase
                end else if (char_byte < CH_SPACE || char_byte > CH_TILDE) begin
                    phase_next = PH_IDLE;
                end
            end
        endcase

        // flag the final result of this item
        if (push_c.cnt == 2'd1) begin
            push_c.res0.last = 1'b1;
        end else if (push_c.cnt == 2'd2) begin
            push_c.res1.last = 1'b1;
        end
    end

    assign push_data = push_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            p1_reg       <= '0;
            p2_reg       <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            attr_reg     <= DEFAULT_ATTR_RESET;
            def_attr_reg <= DEFAULT_ATTR_RESET;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                p1_reg    <= p1_next;
                p2_reg    <= p2_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
                attr_reg  <= attr_next;
            end
            if (cfg_wr_en) begin
                def_attr_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### rtl/core/acsi_out_buf.sv
// Two-entry result buffer between the decode stage and the m_ channel.
// Depends on acsi_pkg.
module acsi_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  acsi_pkg::push_t   push_data,
    input  logic              m_ready,
    output logic              room,
    output logic              m_valid,
    output acsi_pkg::result_t head
);
    import acsi_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    // a push may bring two results, so it needs the buffer empty after this cycle's pop
    assign room    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head    = slot0_reg;

    always_comb begin
        cnt_next   = cnt_reg - 2'(pop);
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push) begin
            cnt_next   = push_data.cnt;
            slot0_next = push_data.res0;
            slot1_next = push_data.res1;
        end else if (pop) begin
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### rtl/core/acsi_checker.sv
// Port-level checks on the terminal's result channel, bound to the top level.
// Depends on acsi_pkg and ansi_csi_text_terminal_macros.svh.
`include "ansi_csi_text_terminal_macros.svh"

module acsi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_op,
    input logic [10:0] m_start_pos,
    input logic [10:0] m_end_pos,
    input logic [15:0] m_cell_word,
    input logic [4:0]  m_scroll_rows,
    input logic        m_last
);
    import acsi_pkg::*;

    `ACSI_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_op) && $stable(m_start_pos) && $stable(m_cell_word),
        "stalled result changed")

    `ACSI_ASSERT_NOW(a_write_shape, m_valid && m_op == OP_WRITE,
        m_start_pos == m_end_pos && m_scroll_rows == '0 && m_start_pos < CELLS,
        "malformed cell write")

    `ACSI_ASSERT_NOW(a_fill_shape, m_valid && m_op == OP_FILL,
        m_start_pos <= m_end_pos && m_end_pos < CELLS && m_scroll_rows == '0
        && m_cell_word[7:0] == CH_SPACE && m_last,
        "malformed fill")

    `ACSI_ASSERT_NOW(a_scroll_shape,
        m_valid && (m_op == OP_SCROLL_UP || m_op == OP_SCROLL_DOWN),
        m_start_pos == '0 && m_end_pos == '0 && m_cell_word == '0
        && m_scroll_rows != '0 && m_scroll_rows <= ROWS,
        "malformed scroll")

    // only a write at the last cell has a follower: the scroll-up it causes
    `ACSI_ASSERT_NEXT(a_pair_follows, m_valid && m_ready && !m_last,
        m_valid && m_op == OP_SCROLL_UP && m_last,
        "first of two results not followed by its scroll")

endmodule

bind ansi_csi_text_terminal acsi_checker u_acsi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_op          (m_op),
    .m_start_pos   (m_start_pos),
    .m_end_pos     (m_end_pos),
    .m_cell_word   (m_cell_word),
    .m_scroll_rows (m_scroll_rows),
    .m_last        (m_last)
);
